@@ sv/dwt53_pkg.sv @@
// Shared types, constants and arithmetic helpers for the 2-D 5/3 wavelet block.
`default_nettype none

package dwt53_pkg;

  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned DIM_W       = 7;
  localparam int unsigned COORD_W     = 6;
  localparam int unsigned STORE_DEPTH = 4096;
  localparam int unsigned ADDR_W      = 12;
  localparam int unsigned CNT_W       = 13;
  localparam int unsigned BLK_W       = 6;
  localparam int unsigned ACC_W       = 20;
  localparam int unsigned STEP_W      = 4;
  localparam int unsigned NB_COUNT    = 9;

  localparam logic [DIM_W-1:0] MAX_DIM = 7'd64;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_FETCH = 1'b1;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Neighbor order within a 3x3 window, row by row.
  localparam logic [STEP_W-1:0] NB_TL = 4'd0;
  localparam logic [STEP_W-1:0] NB_TC = 4'd1;
  localparam logic [STEP_W-1:0] NB_TR = 4'd2;
  localparam logic [STEP_W-1:0] NB_CL = 4'd3;
  localparam logic [STEP_W-1:0] NB_CC = 4'd4;
  localparam logic [STEP_W-1:0] NB_CR = 4'd5;
  localparam logic [STEP_W-1:0] NB_BL = 4'd6;
  localparam logic [STEP_W-1:0] NB_BC = 4'd7;
  localparam logic [STEP_W-1:0] NB_BR = 4'd8;

  localparam logic [STEP_W-1:0] NB_LAST = NB_BR;
  localparam logic [STEP_W-1:0] WR_LAST = 4'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH_ADDR,
    ST_FETCH_DATA,
    ST_READ,
    ST_DRAIN,
    ST_CALC1,
    ST_CALC2,
    ST_WRITE
  } state_e;

  typedef struct packed {
    logic              load;
    logic              fetch;
    logic              fetch_out;
    logic              upd;
    logic [STEP_W-1:0] step;
    logic              rd;
    logic              calc1;
    logic              calc2;
    logic              wr;
    logic              blk_rst;
    logic              blk_next;
    logic              set_done;
  } cmd_t;

  typedef struct packed {
    logic load_trig;
    logic blk_last;
    logic out_free;
  } sts_t;

  function automatic logic signed [ACC_W-1:0] sx(input logic signed [SAMPLE_W-1:0] v);
    sx = {{(ACC_W-SAMPLE_W){v[SAMPLE_W-1]}}, v};
  endfunction

  // Add half, then arithmetic shift by 1 (predict) or 2 (update).
  function automatic logic signed [ACC_W-1:0] rnd(input logic signed [ACC_W-1:0] v,
                                                  input logic upd);
    logic signed [ACC_W-1:0] t;
    t = v + (upd ? ACC_W'(2) : ACC_W'(1));
    rnd = upd ? (t >>> 2) : (t >>> 1);
  endfunction

endpackage

`default_nettype wire

@@ sv/dwt53_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module dwt53_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

@@ sv/dwt53_dpath.sv @@
// Datapath: stores, counters, neighbor window, lifting arithmetic and output register.
`default_nettype none

module dwt53_dpath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire dwt53_pkg::cmd_t               cmd_i,
  output dwt53_pkg::sts_t                    sts_o,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_idx_i,
  input  wire logic [dwt53_pkg::DIM_W-1:0]   cfg_data_i,
  input  wire logic [dwt53_pkg::SAMPLE_W-1:0] sample_i,
  input  wire logic                          m_ready_i,
  output logic                               m_valid_o,
  output logic [dwt53_pkg::SAMPLE_W-1:0]     m_data_o,
  output logic                               m_user_o,
  output logic                               m_last_o
);
  import dwt53_pkg::*;

  logic [DIM_W-1:0] wreg_q, hreg_q;
  logic [DIM_W-1:0] w, h;
  logic [CNT_W-1:0] n;

  logic [CNT_W-1:0] lc_q, rc_q;
  logic             done_q;
  logic [CNT_W-1:0] lc_base, lc_next, rc_next;

  logic [BLK_W-1:0] i_q, j_q;
  logic             last_x, last_y;

  logic signed [SAMPLE_W-1:0] nb_q [NB_COUNT];
  logic                       cap_v_q, cap_in_q;
  logic [STEP_W-1:0]          cap_k_q;

  logic signed [ACC_W-1:0] a_q, b_q, c_q, d_q, e_q;
  logic signed [ACC_W-1:0] a_d, b_d, c_d, d_d, e_d;
  logic signed [ACC_W-1:0] tl, tc, tr, cl, cc, cr, bl, bc, br;

  logic signed [COORD_W+2:0] cx, cy, nx, ny, dx, dy;
  logic                      rd_in;
  logic [CNT_W-1:0]          rd_sum;
  logic [ADDR_W-1:0]         nb_addr;

  logic [COORD_W+1:0]        wx, wy;
  logic [DIM_W-1:0]          hw, hh;
  logic                      wr_ok;
  logic [CNT_W-1:0]          wr_sum;
  logic [ADDR_W-1:0]         wr_addr;
  logic signed [ACC_W-1:0]   wr_val;

  logic                      f_we, s_we;
  logic [ADDR_W-1:0]         f_waddr, f_raddr;
  logic [SAMPLE_W-1:0]       f_wdata, f_rdata, s_rdata, rd_data;

  logic                      m_valid_q, m_user_q, m_last_q;
  logic [SAMPLE_W-1:0]       m_data_q;

  // Effective frame size: zero acts as one, anything above the maximum is clipped.
  assign w = (wreg_q == '0) ? DIM_W'(1) : ((wreg_q > MAX_DIM) ? MAX_DIM : wreg_q);
  assign h = (hreg_q == '0) ? DIM_W'(1) : ((hreg_q > MAX_DIM) ? MAX_DIM : hreg_q);
  assign n = CNT_W'(w) * CNT_W'(h);
  assign hw = DIM_W'((w + DIM_W'(1)) >> 1);
  assign hh = DIM_W'((h + DIM_W'(1)) >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wreg_q <= MAX_DIM;
      hreg_q <= MAX_DIM;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WIDTH:  wreg_q <= cfg_data_i;
        REG_HEIGHT: hreg_q <= cfg_data_i;
        default:    wreg_q <= wreg_q;
      endcase
    end
  end

  // Load and readout counters.
  assign lc_base = done_q ? '0 : lc_q;
  assign lc_next = lc_base + CNT_W'(1);
  assign rc_next = rc_q + CNT_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lc_q   <= '0;
      rc_q   <= '0;
      done_q <= 1'b0;
    end else if (cmd_i.load) begin
      done_q <= 1'b0;
      rc_q   <= '0;
      lc_q   <= (lc_next >= n) ? '0 : lc_next;
    end else if (cmd_i.set_done) begin
      done_q <= 1'b1;
      lc_q   <= '0;
      rc_q   <= '0;
    end else if (cmd_i.fetch_out && done_q) begin
      if (rc_next >= n) begin
        rc_q   <= '0;
        lc_q   <= '0;
        done_q <= 1'b0;
      end else begin
        rc_q <= rc_next;
      end
    end
  end

  // Block walk over 2x2 groups.
  assign last_x = ({1'b0, i_q} + DIM_W'(1)) << 1 >= w;
  assign last_y = ({1'b0, j_q} + DIM_W'(1)) << 1 >= h;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q <= '0;
      j_q <= '0;
    end else if (cmd_i.blk_rst) begin
      i_q <= '0;
      j_q <= '0;
    end else if (cmd_i.blk_next) begin
      if (last_x) begin
        i_q <= '0;
        j_q <= j_q + BLK_W'(1);
      end else begin
        i_q <= i_q + BLK_W'(1);
      end
    end
  end

  // Window center: odd positions in the predict pass, even in the update pass.
  assign cx = $signed({2'b00, i_q, ~cmd_i.upd});
  assign cy = $signed({2'b00, j_q, ~cmd_i.upd});

  always_comb begin
    case (cmd_i.step)
      NB_TL:   begin dx = -9'sd1; dy = -9'sd1; end
      NB_TC:   begin dx =  9'sd0; dy = -9'sd1; end
      NB_TR:   begin dx =  9'sd1; dy = -9'sd1; end
      NB_CL:   begin dx = -9'sd1; dy =  9'sd0; end
      NB_CC:   begin dx =  9'sd0; dy =  9'sd0; end
      NB_CR:   begin dx =  9'sd1; dy =  9'sd0; end
      NB_BL:   begin dx = -9'sd1; dy =  9'sd1; end
      NB_BC:   begin dx =  9'sd0; dy =  9'sd1; end
      NB_BR:   begin dx =  9'sd1; dy =  9'sd1; end
      default: begin dx =  9'sd0; dy =  9'sd0; end
    endcase
  end

  assign nx = cx + dx;
  assign ny = cy + dy;
  assign rd_in = !nx[COORD_W+2] && !ny[COORD_W+2] &&
                 (nx < $signed({2'b00, w})) && (ny < $signed({2'b00, h}));
  assign rd_sum  = CNT_W'(ny[COORD_W-1:0]) * CNT_W'(w) + CNT_W'(nx[COORD_W-1:0]);
  assign nb_addr = rd_sum[ADDR_W-1:0];

  assign rd_data = cmd_i.upd ? s_rdata : f_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_v_q <= 1'b0;
    end else begin
      cap_v_q <= cmd_i.rd;
    end
  end

  always_ff @(posedge clk_i) begin
    cap_k_q  <= cmd_i.step;
    cap_in_q <= rd_in;
    if (cap_v_q) begin
      nb_q[cap_k_q] <= cap_in_q ? rd_data : '0;
    end
  end

  // Lifting arithmetic, exact in ACC_W bits, split over two steps.
  assign tl = sx(nb_q[NB_TL]);
  assign tc = sx(nb_q[NB_TC]);
  assign tr = sx(nb_q[NB_TR]);
  assign cl = sx(nb_q[NB_CL]);
  assign cc = sx(nb_q[NB_CC]);
  assign cr = sx(nb_q[NB_CR]);
  assign bl = sx(nb_q[NB_BL]);
  assign bc = sx(nb_q[NB_BC]);
  assign br = sx(nb_q[NB_BR]);

  always_comb begin
    if (cmd_i.upd) begin
      a_d = cr + rnd(tr + br, 1'b1);
      b_d = bc + rnd(bl + br, 1'b1);
      c_d = cl + rnd(tl + bl, 1'b1);
      d_d = rnd(tc + bc, 1'b1);
      e_d = cc + d_q + rnd(c_q + a_q, 1'b1);
    end else begin
      a_d = tc - rnd(tl + tr, 1'b0);
      b_d = bc - rnd(bl + br, 1'b0);
      c_d = cl - rnd(tl + bl, 1'b0);
      d_d = rnd(cl + cr, 1'b0);
      e_d = cc - d_q - rnd(a_q + b_q, 1'b0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc1) begin
      a_q <= a_d;
      b_q <= b_d;
      c_q <= c_d;
      d_q <= d_d;
    end
    if (cmd_i.calc2) begin
      e_q <= e_d;
    end
  end

  // Write targets: original positions in the scratch store for predict, subband layout for update.
  always_comb begin
    wx     = '0;
    wy     = '0;
    wr_ok  = 1'b1;
    wr_val = e_q;
    if (cmd_i.upd) begin
      case (cmd_i.step)
        4'd0: begin
          wx = {2'b00, i_q}; wy = {2'b00, j_q}; wr_val = e_q;
        end
        4'd1: begin
          wx = {2'b00, i_q} + {1'b0, hw}; wy = {2'b00, j_q}; wr_val = a_q;
          wr_ok = !last_x || ({i_q, 1'b1} < w);
        end
        4'd2: begin
          wx = {2'b00, i_q}; wy = {2'b00, j_q} + {1'b0, hh}; wr_val = b_q;
          wr_ok = ({j_q, 1'b1} < h);
        end
        default: begin
          wx = {2'b00, i_q} + {1'b0, hw}; wy = {2'b00, j_q} + {1'b0, hh}; wr_val = br;
          wr_ok = ({i_q, 1'b1} < w) && ({j_q, 1'b1} < h);
        end
      endcase
      wr_ok = wr_ok && ({i_q, 1'b1} < w || cmd_i.step == 4'd0 || cmd_i.step == 4'd2);
    end else begin
      case (cmd_i.step)
        4'd0:    begin wx = {1'b0, i_q, 1'b1}; wy = {1'b0, j_q, 1'b1}; wr_val = e_q; end
        4'd1:    begin wx = {1'b0, i_q, 1'b1}; wy = {1'b0, j_q, 1'b0}; wr_val = a_q; end
        4'd2:    begin wx = {1'b0, i_q, 1'b0}; wy = {1'b0, j_q, 1'b1}; wr_val = c_q; end
        default: begin wx = {1'b0, i_q, 1'b0}; wy = {1'b0, j_q, 1'b0}; wr_val = tl; end
      endcase
    end
    wr_ok = wr_ok && (wx < {1'b0, w}) && (wy < {1'b0, h});
  end

  assign wr_sum  = CNT_W'(wy[COORD_W-1:0]) * CNT_W'(w) + CNT_W'(wx[COORD_W-1:0]);
  assign wr_addr = wr_sum[ADDR_W-1:0];

  // Frame store: loads and update results in, predict pass and readout out.
  assign f_we    = cmd_i.load || (cmd_i.wr && cmd_i.upd && wr_ok);
  assign f_waddr = cmd_i.load ? lc_base[ADDR_W-1:0] : wr_addr;
  assign f_wdata = cmd_i.load ? sample_i : wr_val[SAMPLE_W-1:0];
  assign f_raddr = cmd_i.fetch ? rc_q[ADDR_W-1:0] : nb_addr;
  assign s_we    = cmd_i.wr && !cmd_i.upd && wr_ok;

  dwt53_ram #(.WIDTH(SAMPLE_W), .DEPTH(STORE_DEPTH)) u_frame (
    .clk_i   (clk_i),
    .we_i    (f_we),
    .waddr_i (f_waddr),
    .wdata_i (f_wdata),
    .raddr_i (f_raddr),
    .rdata_o (f_rdata)
  );

  dwt53_ram #(.WIDTH(SAMPLE_W), .DEPTH(STORE_DEPTH)) u_scratch (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (wr_addr),
    .wdata_i (wr_val[SAMPLE_W-1:0]),
    .raddr_i (nb_addr),
    .rdata_o (s_rdata)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.fetch_out) begin
      m_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fetch_out) begin
      m_data_q <= done_q ? f_rdata : '0;
      m_user_q <= done_q;
      m_last_q <= done_q && (rc_next >= n);
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;
  assign m_user_o  = m_user_q;
  assign m_last_o  = m_last_q;

  assign sts_o.load_trig = lc_next >= n;
  assign sts_o.blk_last  = last_x && last_y;
  assign sts_o.out_free  = !m_valid_q || m_ready_i;

endmodule

`default_nettype wire

@@ sv/dwt53_ctrl.sv @@
// Controller: sequences loads, fetches and the two lifting passes.
`default_nettype none

module dwt53_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            s_valid_i,
  input  wire logic            s_kind_i,
  output logic                 s_ready_o,
  input  wire dwt53_pkg::sts_t sts_i,
  output dwt53_pkg::cmd_t      cmd_o
);
  import dwt53_pkg::*;

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              pass_q, pass_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      pass_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      pass_q  <= pass_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    pass_d    = pass_q;
    s_ready_o = 1'b0;
    cmd_o     = '0;
    cmd_o.upd  = pass_q;
    cmd_o.step = step_q;
    case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          if (s_kind_i == KIND_LOAD) begin
            cmd_o.load = 1'b1;
            if (sts_i.load_trig) begin
              cmd_o.blk_rst = 1'b1;
              pass_d  = 1'b0;
              step_d  = '0;
              state_d = ST_READ;
            end
          end else begin
            state_d = ST_FETCH_ADDR;
          end
        end
      end
      ST_FETCH_ADDR: begin
        cmd_o.fetch = 1'b1;
        state_d = ST_FETCH_DATA;
      end
      ST_FETCH_DATA: begin
        cmd_o.fetch = 1'b1;
        if (sts_i.out_free) begin
          cmd_o.fetch_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
        if (step_q == NB_LAST) begin
          step_d  = '0;
          state_d = ST_DRAIN;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      ST_DRAIN: begin
        state_d = ST_CALC1;
      end
      ST_CALC1: begin
        cmd_o.calc1 = 1'b1;
        state_d = ST_CALC2;
      end
      ST_CALC2: begin
        cmd_o.calc2 = 1'b1;
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        cmd_o.wr = 1'b1;
        if (step_q == WR_LAST) begin
          step_d = '0;
          if (!sts_i.blk_last) begin
            cmd_o.blk_next = 1'b1;
            state_d = ST_READ;
          end else if (!pass_q) begin
            cmd_o.blk_rst = 1'b1;
            pass_d  = 1'b1;
            state_d = ST_READ;
          end else begin
            cmd_o.set_done = 1'b1;
            state_d = ST_IDLE;
          end
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.fetch_out |-> sts_i.out_free)
    else $error("result loaded while output register is occupied");

  a_rd_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> (step_q <= NB_LAST))
    else $error("neighbor read step out of range");

  a_wr_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRITE) |-> (step_q <= WR_LAST))
    else $error("write step out of range");

  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load && sts_i.load_trig) |=> (state_q == ST_READ && !pass_q && step_q == '0))
    else $error("full frame did not start the predict pass");

endmodule

`default_nettype wire

@@ sv/dwt53_forward_2d.sv @@
// Top level of the one-level 2-D 5/3 lifting wavelet transform.
//
// A load transaction (tuser 0) writes one signed sample into the frame store in raster
// order. When frame_width*frame_height samples have arrived the block runs a predict
// pass into a scratch store and an update pass back into the frame store, laid out as
// LL, HL, LH and HH quadrants split at half the size rounded up. Each pass walks the
// 2x2 groups of the frame, and for each does nine neighbor reads through the single
// read port of the store, a drain state for the last read data, the arithmetic in
// states CALC1 and CALC2, and four writes. No transaction is accepted while the
// transform runs. A fetch transaction (tuser 1) is accepted, presents the store
// address, then loads the store data into the output register once it is free; it
// returns the next coefficient in raster order with tuser 1, and tlast on the final
// one. A fetch before the frame has been transformed returns zero with tuser 0.
// Configuration writes are taken at any time but must only be made while the block
// is idle.
`default_nettype none

module dwt53_forward_2d (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [dwt53_pkg::SAMPLE_W-1:0] s_axis_tdata,  // [15:0] sample
  input  wire logic                          s_axis_tuser,   // [0] kind
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [dwt53_pkg::SAMPLE_W-1:0]     m_axis_tdata,   // [15:0] coefficient
  output logic                               m_axis_tuser,   // [0] valid_res
  output logic                               m_axis_tlast,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_idx_i,
  input  wire logic [dwt53_pkg::DIM_W-1:0]   cfg_data_i
);
  import dwt53_pkg::*;

  cmd_t cmd;
  sts_t sts;

  dwt53_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_kind_i  (s_axis_tuser),
    .s_ready_o (s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  dwt53_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .sample_i   (s_axis_tdata),
    .m_ready_i  (m_axis_tready),
    .m_valid_o  (m_axis_tvalid),
    .m_data_o   (m_axis_tdata),
    .m_user_o   (m_axis_tuser),
    .m_last_o   (m_axis_tlast)
  );

endmodule

`default_nettype wire

@@ test/tb.sv @@
// Self-checking testbench for the one-level 2-D 5/3 lifting wavelet block.
`timescale 1ns / 100ps

module tb;
  import dwt53_pkg::*;

  // One coefficient transaction as the block should return it.
  typedef struct {
    logic [SAMPLE_W-1:0] coef;
    logic                vld;
    logic                lst;
  } coef_t;

  // The scoreboard carries its own copy of the block state. Every accepted
  // input transaction is pushed through the transform model below, and each
  // fetch leaves one expected coefficient behind in coef_q.
  class coef_scoreboard;
    int    fs[STORE_DEPTH];
    int    ss[STORE_DEPTH];
    int    load_cnt;
    int    rd_cnt;
    bit    done;
    int    w_reg;
    int    h_reg;
    int    errors;
    coef_t coef_q[$];

    function new();
      foreach (fs[i]) begin
        fs[i] = 0;
        ss[i] = 0;
      end
      load_cnt = 0;
      rd_cnt   = 0;
      done     = 0;
      w_reg    = 64;
      h_reg    = 64;
      errors   = 0;
    endfunction

    function void set_reg(logic idx, int val);
      if (idx == REG_WIDTH) w_reg = val & 8'h7f;
      else h_reg = val & 8'h7f;
    endfunction

    function int eff_dim(int v);
      if (v < 1) return 1;
      if (v > 64) return 64;
      return v;
    endfunction

    function longint px(bit scr, int w, int h, int x, int y);
      if (x < 0 || y < 0 || x >= w || y >= h) return 0;
      return scr ? ss[y*w+x] : fs[y*w+x];
    endfunction

    function void put(bit scr, int w, int h, int x, int y, longint v);
      logic signed [SAMPLE_W-1:0] t;
      if (x < 0 || y < 0 || x >= w || y >= h) return;
      t = v[SAMPLE_W-1:0];
      if (scr) ss[y*w+x] = t;
      else fs[y*w+x] = t;
    endfunction

    // Add half, then shift right arithmetically.
    function longint rnd_shift(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function void transform(int w, int h);
      int hw, hh;
      longint tl, tc, tr, cl, cc, cr, bl, bc, br;
      hw = (w + 1) >> 1;
      hh = (h + 1) >> 1;
      // Predict pass, frame store into scratch store.
      for (int y = 1; y - 1 < h; y += 2)
        for (int x = 1; x - 1 < w; x += 2) begin
          tl = px(0, w, h, x-1, y-1); tc = px(0, w, h, x, y-1); tr = px(0, w, h, x+1, y-1);
          cl = px(0, w, h, x-1, y);   cc = px(0, w, h, x, y);   cr = px(0, w, h, x+1, y);
          bl = px(0, w, h, x-1, y+1); bc = px(0, w, h, x, y+1); br = px(0, w, h, x+1, y+1);
          tc -= rnd_shift(tl + tr, 1);
          bc -= rnd_shift(bl + br, 1);
          cc -= rnd_shift(cl + cr, 1) + rnd_shift(tc + bc, 1);
          cl -= rnd_shift(tl + bl, 1);
          put(1, w, h, x, y, cc);
          put(1, w, h, x, y-1, tc);
          put(1, w, h, x-1, y, cl);
          put(1, w, h, x-1, y-1, tl);
        end
      // Update pass, scratch store back into the frame store as subbands.
      for (int y = 0; y < h; y += 2)
        for (int x = 0; x < w; x += 2) begin
          tl = px(1, w, h, x-1, y-1); tc = px(1, w, h, x, y-1); tr = px(1, w, h, x+1, y-1);
          cl = px(1, w, h, x-1, y);   cc = px(1, w, h, x, y);   cr = px(1, w, h, x+1, y);
          bl = px(1, w, h, x-1, y+1); bc = px(1, w, h, x, y+1); br = px(1, w, h, x+1, y+1);
          cl += rnd_shift(tl + bl, 2);
          cr += rnd_shift(tr + br, 2);
          cc += rnd_shift(cl + cr, 2) + rnd_shift(tc + bc, 2);
          bc += rnd_shift(bl + br, 2);
          put(0, w, h, x >> 1, y >> 1, cc);
          if (x + 1 < w) put(0, w, h, (x >> 1) + hw, y >> 1, cr);
          if (y + 1 < h) put(0, w, h, x >> 1, (y >> 1) + hh, bc);
          if (x + 1 < w && y + 1 < h) put(0, w, h, (x >> 1) + hw, (y >> 1) + hh, br);
        end
    endfunction

    function void note_input(logic kind, logic [SAMPLE_W-1:0] sample);
      int    w, h, n;
      coef_t e;
      w = eff_dim(w_reg);
      h = eff_dim(h_reg);
      n = w * h;
      if (kind == KIND_LOAD) begin
        if (done) begin
          done     = 0;
          rd_cnt   = 0;
          load_cnt = 0;
        end
        fs[load_cnt % STORE_DEPTH] = $signed(sample);
        load_cnt = (load_cnt + 1) & 13'h1fff;
        if (load_cnt >= n) begin
          transform(w, h);
          done     = 1;
          load_cnt = 0;
          rd_cnt   = 0;
        end
      end else if (!done) begin
        e.coef = '0;
        e.vld  = 1'b0;
        e.lst  = 1'b0;
        coef_q.push_back(e);
      end else begin
        e.coef = SAMPLE_W'(fs[rd_cnt % STORE_DEPTH]);
        e.vld  = 1'b1;
        if (rd_cnt + 1 >= n) begin
          e.lst    = 1'b1;
          rd_cnt   = 0;
          load_cnt = 0;
          done     = 0;
        end else begin
          e.lst  = 1'b0;
          rd_cnt = (rd_cnt + 1) & 13'h1fff;
        end
        coef_q.push_back(e);
      end
    endfunction

    function void report(string what);
      $display("ERROR at %0t: %s", $realtime, what);
      errors++;
    endfunction

    function void check(logic [SAMPLE_W-1:0] coef, logic vld, logic lst);
      coef_t e;
      if (coef_q.size() == 0) begin
        report($sformatf("unexpected coefficient %h", coef));
        return;
      end
      e = coef_q.pop_front();
      if (coef !== e.coef)
        report($sformatf("coefficient %h, expected %h", coef, e.coef));
      if (vld !== e.vld)
        report($sformatf("tuser %b, expected %b", vld, e.vld));
      if (lst !== e.lst)
        report($sformatf("tlast %b, expected %b", lst, e.lst));
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                s_valid = 1'b0;
  logic [SAMPLE_W-1:0] s_data = '0;
  logic                s_user = 1'b0;
  logic                m_ready = 1'b0;
  logic                cfg_we = 1'b0;
  logic                cfg_idx = 1'b0;
  logic [DIM_W-1:0]    cfg_data = '0;
  wire                 s_ready;
  wire                 m_valid;
  wire [SAMPLE_W-1:0]  m_data;
  wire                 m_user;
  wire                 m_last;

  coef_scoreboard sb = new();
  int             sent = 0;
  int             burst_left = 0;
  int             stall_mode = 0;
  int             stall_cnt = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  dwt53_forward_2d dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tuser  (m_user),
    .m_axis_tlast  (m_last),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data)
  );

  // Output side: every completed transaction is checked against the oldest
  // expectation. The stall mode is drawn at random among no stalls, random
  // stalls and a slow periodic pattern.
  always @(posedge clk) begin
    if (m_valid && m_ready) begin
      sb.check(m_data, m_user, m_last);
    end
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt % 256 == 0) begin
      stall_mode <= $urandom_range(0, 2);
    end
    case (stall_mode)
      0: begin
        m_ready <= 1'b1;
      end
      1: begin
        m_ready <= ($urandom_range(0, 99) < 60);
      end
      default: begin
        m_ready <= (stall_cnt % 7 == 0);
      end
    endcase
  end

  // Sends one input transaction. Bursts of random length alternate with random
  // gaps, and tvalid stays high across back-to-back transactions in a burst.
  task automatic push_item(logic kind, logic [SAMPLE_W-1:0] sample);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    s_valid <= 1'b1;
    s_user  <= kind;
    s_data  <= sample;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    sb.note_input(kind, sample);
    burst_left--;
    sent++;
  endtask

  // Stops sending and waits until every expected coefficient has come back.
  task automatic wait_empty();
    s_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.coef_q.size() != 0) @(posedge clk);
  endtask

  // Brings the block to idle: loads produce no result, so a transform may
  // still run after the last coefficient, and the wait covers its full length.
  task automatic settle();
    int w, h;
    wait_empty();
    w = sb.eff_dim(sb.w_reg);
    h = sb.eff_dim(sb.h_reg);
    repeat (32 * ((w + 1) / 2) * ((h + 1) / 2) + 40) @(posedge clk);
  endtask

  // Reads out the rest of a transformed frame so that a later size change
  // can never point a fetch at a store entry that was never written.
  task automatic finish_readout();
    while (sb.done) push_item(KIND_FETCH, SAMPLE_W'($urandom()));
    settle();
  endtask

  task automatic write_reg(logic idx, int val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val[DIM_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  function automatic int rand_dim();
    case ($urandom_range(0, 15))
      0: return 0;
      1: return 127;
      2: return 64;
      3: return 1;
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  initial begin
    int w, h, n, frames, k;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. A fetch right after reset comes back marked invalid.
    push_item(KIND_FETCH, 16'h1234);
    settle();
    // A zero size acts as one, so a single load completes the frame.
    write_reg(REG_WIDTH, 0);
    write_reg(REG_HEIGHT, 0);
    push_item(KIND_LOAD, 16'h8000);
    push_item(KIND_FETCH, 16'h0000);
    // Readout ended, so the next fetch is invalid again.
    push_item(KIND_FETCH, 16'hffff);
    settle();
    // A 3x3 frame is loaded with alternating extremes.
    write_reg(REG_WIDTH, 3);
    write_reg(REG_HEIGHT, 3);
    for (int i = 0; i < 9; i++) push_item(KIND_LOAD, i[0] ? 16'h8000 : 16'h7fff);
    push_item(KIND_FETCH, 16'h0000);
    push_item(KIND_FETCH, 16'h0000);
    // A load in the middle of readout abandons the rest and starts a frame.
    for (int i = 0; i < 9; i++) push_item(KIND_LOAD, 16'h7fff);
    finish_readout();

    // Random part: phases with a fresh size, mostly whole frames loaded and
    // read out in order, with stray fetches, cut-short readouts and frames
    // left half loaded before the size changes.
    while (sent < 700) begin
      write_reg(REG_WIDTH, rand_dim());
      write_reg(REG_HEIGHT, rand_dim());
      w = sb.eff_dim(sb.w_reg);
      h = sb.eff_dim(sb.h_reg);
      // Keep big frames rare; most phases use small ones.
      if (w * h > 64) write_reg(REG_HEIGHT, 1);
      w = sb.eff_dim(sb.w_reg);
      h = sb.eff_dim(sb.h_reg);
      n = w * h;
      frames = $urandom_range(1, 3);
      for (int f = 0; f < frames; f++) begin
        k = ($urandom_range(0, 7) == 0) ? $urandom_range(0, n - 1) : n;
        for (int i = 0; i < k; i++) begin
          if ($urandom_range(0, 19) == 0) push_item(KIND_FETCH, SAMPLE_W'($urandom()));
          push_item(KIND_LOAD, rand_sample());
        end
        if (sb.done) begin
          k = ($urandom_range(0, 5) == 0) ? $urandom_range(0, n) : n;
          for (int i = 0; i < k; i++) push_item(KIND_FETCH, SAMPLE_W'($urandom()));
          if ($urandom_range(0, 4) == 0) push_item(KIND_FETCH, SAMPLE_W'($urandom()));
        end
        if ($urandom_range(0, 9) == 0) wait_empty();
      end
      finish_readout();
    end

    settle();
    if (sb.errors == 0 && sb.coef_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      if (sb.coef_q.size() != 0) sb.report("coefficients never returned");
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
